// File: rtl/cbf_pkg.sv
// Shared types for the centered box filter with truncated edges.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps

package cbf_pkg;

  // Status flags from the iterative divider back to the control logic.
  typedef struct packed {
    logic busy;
    logic done;
  } cbf_div_status_t;

endpackage

// File: rtl/cbf_stream_if.sv
// Valid/ready stream interfaces for the sample input and the filtered output.
// No dependencies; the sample width is a parameter of each interface.
`timescale 1ns / 1ps

interface cbf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface cbf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic                          last_out;

  modport source (output valid, output smoothed, output last_out, input ready);
  modport sink   (input valid, input smoothed, input last_out, output ready);
endinterface

// File: rtl/cbf_window_mem.sv
// Circular sample store of the filter window: one write port, one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module cbf_window_mem #(
  parameter int DEPTH = 15,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbf_divider.sv
// Iterative rounded divider: sum / count, rounded to nearest, ties away from zero.
// One quotient bit per cycle; depends on cbf_pkg for the status struct.
`timescale 1ns / 1ps

module cbf_divider #(
  parameter int SUM_W       = 20,
  parameter int CNT_W       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       sum_i,
  input  logic [CNT_W-1:0]              cnt_i,
  output cbf_pkg::cbf_div_status_t      status_o,
  output logic signed [SAMPLE_BITS-1:0] quot_o
);

  import cbf_pkg::*;

  // The dividend is 2*|sum| + cnt, the divisor is 2*cnt.
  localparam int DW = SUM_W + 1;
  localparam int RW = CNT_W + 1;
  localparam int IW = $clog2(DW + 1);

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [IW-1:0]    iter_q, iter_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             ge;
  logic [SUM_W-1:0] mag;
  logic [SAMPLE_BITS-1:0] quot_mag;

  // One restoring step: bring in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    mag   = sum_i[SUM_W-1] ? (SUM_W)'(-sum_i) : sum_i;
  end

  // Load on start, then iterate once per cycle until every bit is done.
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {mag, 1'b0} + {{(DW-CNT_W){1'b0}}, cnt_i};
      rem_d  = '0;
      dvs_d  = {cnt_i, 1'b0};
      neg_d  = sum_i[SUM_W-1];
      iter_d = IW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[RW-1:0] : trial[RW-1:0];
      dvd_d  = {dvd_q[DW-2:0], ge};
      iter_d = iter_q - 1'b1;
      if (iter_q == IW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // The mean of in-range samples always fits the sample width.
  assign quot_mag      = dvd_q[SAMPLE_BITS-1:0];
  assign quot_o        = neg_q ? $signed(-quot_mag) : $signed(quot_mag);
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: rtl/centered_box_filter_edge_truncated_unit.sv
// Centered box filter with edges truncated at frame boundaries.
//
// Input channel in_i carries one signed sample per item plus a last-of-frame
// flag; output channel out_o carries one windowed mean per item plus a flag
// on the final output of the frame. Output q is the mean of the samples at
// q-RADIUS .. q+RADIUS inside the frame, rounded to nearest, ties away from 0.
// The first output appears with input item RADIUS+1; the last input item
// releases the remaining min(frame length, RADIUS+1) outputs.
// An item is accepted only while the block is idle, so it takes one item at a time:
// each mean goes through the bit-serial divider's SUM_W+1 steps before the next
// item is taken. Each tail output at frame end needs another division, preceded
// by a read of the oldest sample when the window shrinks.
// The window lives in a circular memory with a registered read port; the
// oldest entry is read, then the running sum is updated and the new sample
// written back. Results sit in an output register, so a stalled receiver
// does not block the next input item unless a second result is ready.
// Reset clears the fill count, running sum and pointer; no memory sweep is
// needed since only entries written in the current frame are ever used.
`timescale 1ns / 1ps

module centered_box_filter_edge_truncated_unit #(
  parameter int RADIUS      = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbf_in_if.sink    in_i,
  cbf_out_if.source out_o
);

  import cbf_pkg::*;

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int CNT_W = $clog2(SPAN + 1);
  localparam int PTR_W = $clog2(SPAN);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int SB    = SAMPLE_BITS;

  localparam logic [CNT_W-1:0] SPAN_C = CNT_W'(SPAN);
  localparam logic [CNT_W-1:0] RAD_C  = CNT_W'(RADIUS);
  localparam logic [CNT_W-1:0] RAD1_C = CNT_W'(RADIUS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SPAN - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_OUT,
    S_TSUB
  } state_e;

  state_e                  state_q, state_d;
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SB-1:0]           sample_q, sample_d;
  logic                    last_q, last_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic                    ovalid_q, ovalid_d;
  logic signed [SB-1:0]    osmooth_q, osmooth_d;
  logic                    olast_q, olast_d;

  logic                    mem_we;
  logic                    mem_re;
  logic [PTR_W-1:0]        mem_raddr;
  logic [SB-1:0]           mem_rdata;

  logic                    div_start;
  cbf_div_status_t         div_status;
  logic signed [SB-1:0]    div_quot;

  logic                    full;
  logic [CNT_W-1:0]        fill_n;
  logic [CNT_W-1:0]        fill_m1;
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] smp_ext;
  logic [CNT_W:0]          old_sum;
  logic [PTR_W-1:0]        old_addr;
  logic                    out_free;

  // Window memory and the shared divider.
  cbf_window_mem #(
    .DEPTH (SPAN),
    .WIDTH (SB),
    .AW    (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (sample_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cbf_divider #(
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .SAMPLE_BITS (SB)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .sum_i    (sum_d),
    .cnt_i    (fill_d),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  // Helper values: sign extension, fill update and the oldest held entry.
  always_comb begin
    full     = (fill_q == SPAN_C);
    fill_n   = full ? fill_q : fill_q + 1'b1;
    fill_m1  = fill_n - 1'b1;
    rd_ext   = {{(SUM_W-SB){mem_rdata[SB-1]}}, mem_rdata};
    smp_ext  = {{(SUM_W-SB){sample_q[SB-1]}}, sample_q};
    old_sum  = {{(CNT_W+1-PTR_W){1'b0}}, wr_ptr_q} + {1'b0, SPAN_C} - {1'b0, fill_q};
    old_addr = (old_sum >= {1'b0, SPAN_C}) ? PTR_W'(old_sum - {1'b0, SPAN_C})
                                           : old_sum[PTR_W-1:0];
    out_free = !ovalid_q || out_o.ready;
  end

  // Control sequence: read oldest, update and write, divide, present, shrink tail.
  always_comb begin
    state_d   = state_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    sample_d  = sample_q;
    last_d    = last_q;
    j_d       = j_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    osmooth_d = osmooth_q;
    olast_d   = olast_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = wr_ptr_q;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          sample_d = in_i.sample_in;
          last_d   = in_i.last_in;
          mem_re   = 1'b1;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        mem_we   = 1'b1;
        sum_d    = sum_q - (full ? rd_ext : '0) + smp_ext;
        fill_d   = fill_n;
        wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
        if (last_q) begin
          j_d       = (fill_m1 > RAD_C) ? RAD_C : fill_m1;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (fill_n >= RAD1_C) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          osmooth_d = div_quot;
          olast_d   = last_q && (j_q == '0);
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (j_q == '0) begin
            // Frame done: start the next one from an empty window.
            fill_d   = '0;
            sum_d    = '0;
            wr_ptr_d = '0;
            last_d   = 1'b0;
            state_d  = S_IDLE;
          end else begin
            j_d = j_q - 1'b1;
            if ((j_q + RAD_C) < fill_q) begin
              // Window shrinks at the tail: drop the oldest sample first.
              mem_re    = 1'b1;
              mem_raddr = old_addr;
              state_d   = S_TSUB;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        end
      end
      S_TSUB: begin
        sum_d     = sum_q - rd_ext;
        fill_d    = fill_q - 1'b1;
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      last_q   <= 1'b0;
      j_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      last_q   <= last_d;
      j_q      <= j_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    osmooth_q <= osmooth_d;
    olast_q   <= olast_d;
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = ovalid_q;
  assign out_o.smoothed = osmooth_q;
  assign out_o.last_out = olast_q;

endmodule

// File: test/centered_box_filter_edge_truncated_unit_chk.sv
// Result checker for the centered box filter: watches both stream channels,
// predicts every windowed mean from the accepted samples and compares.
// Depends on the cbf_in_if and cbf_out_if interfaces of the RTL.
`timescale 1ns / 1ps

module centered_box_filter_edge_truncated_unit_chk #(
  parameter int RADIUS      = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cbf_in_if    in_mon,
  cbf_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);

  localparam int SPAN = 2 * RADIUS + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          last_out;
  } mean_item_t;

  // Predictor state: newest sample at index 0.
  logic signed [SAMPLE_BITS-1:0] taps [SPAN];
  longint                        frame_sum;
  int                            frame_fill;
  mean_item_t                    means_q [$];
  int                            mismatches;

  // Sum divided by count, rounded to nearest with ties away from zero.
  function automatic logic signed [SAMPLE_BITS-1:0] rounded_mean(input longint total,
                                                                 input int cnt);
    longint mag;
    longint q;
    mag = (total < 0) ? -total : total;
    q   = (2 * mag + cnt) / (2 * cnt);
    return SAMPLE_BITS'((total < 0) ? -q : q);
  endfunction

  task clear_frame();
    for (int k = 0; k < SPAN; k++) taps[k] = '0;
    frame_sum  = 0;
    frame_fill = 0;
  endtask

  // Shift one sample in and queue the means it releases.
  task predict_means(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    int         first_j;
    int         cnt;
    longint     acc;
    mean_item_t m;
    if (frame_fill >= SPAN) frame_sum -= taps[SPAN-1];
    for (int k = SPAN - 1; k > 0; k--) taps[k] = taps[k-1];
    taps[0]   = s;
    frame_sum += s;
    if (frame_fill < SPAN) frame_fill++;

    if (!last) begin
      if (frame_fill >= RADIUS + 1) begin
        m.smoothed = rounded_mean(frame_sum, frame_fill);
        m.last_out = 1'b0;
        means_q = {means_q, m};
      end
    end else begin
      // Flush: the tail windows shrink toward the end of the frame.
      first_j = (frame_fill - 1 > RADIUS) ? RADIUS : frame_fill - 1;
      for (int j = first_j; j >= 0; j--) begin
        cnt = (j + RADIUS + 1 < frame_fill) ? j + RADIUS + 1 : frame_fill;
        acc = 0;
        for (int k = 0; k < cnt; k++) acc += taps[k];
        m.smoothed = rounded_mean(acc, cnt);
        m.last_out = (j == 0);
        means_q = {means_q, m};
      end
      clear_frame();
    end
  endtask

  // Both channels are sampled at the edge; inputs are handled before outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    mean_item_t want;
    if (!rst_ni) begin
      clear_frame();
      means_q.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_means(in_mon.sample_in, in_mon.last_in);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (means_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result smoothed=%0d last_out=%0b", $time,
                   out_mon.smoothed, out_mon.last_out);
        end else begin
          want = means_q.pop_front();
          if (want.smoothed !== out_mon.smoothed || want.last_out !== out_mon.last_out) begin
            mismatches++;
            $display("%0t: expected smoothed=%0d last_out=%0b, got smoothed=%0d last_out=%0b",
                     $time, want.smoothed, want.last_out, out_mon.smoothed,
                     out_mon.last_out);
          end
        end
      end
      errors_o  <= mismatches;
      pending_o <= means_q.size();
    end
  end

endmodule

// File: test/centered_box_filter_edge_truncated_unit_tb.sv
// Top of the box filter testbench: clock, reset, sample frames, output stalls.
// Depends on the RTL package, interfaces and top level, and on the checker.
`timescale 1ns / 1ps

module centered_box_filter_edge_truncated_unit_tb;

  localparam int RADIUS          = 7;
  localparam int SAMPLE_BITS     = 16;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 100;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   hold_asked = 0;

  cbf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  cbf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  centered_box_filter_edge_truncated_unit #(
    .RADIUS     (RADIUS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  centered_box_filter_edge_truncated_unit_chk #(
    .RADIUS     (RADIUS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("centered_box_filter_edge_truncated_unit: mismatch");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_served;
    hold_served  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        out_if.ready <= 1'b0;
        for (int held = 1; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item, with random idle cycles first, and wait until it is taken.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    in_if.last_in   <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop offering and wait until every predicted mean has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly full-range samples, with extremes and values near zero for ties.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SMIN;
      1:       return SMAX;
      2, 3:    return SAMPLE_BITS'($urandom_range(16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Stimulus: directed frames, then four phases of random frames with varied input idling and output stalls.
  initial begin
    int sent;
    int len;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    in_if.last_in   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-sample frames at both extremes.
    send_sample(SMIN, 1'b1);
    send_sample(SMAX, 1'b1);
    // Two-sample frame whose mean is a tie, rounded away from zero.
    send_sample(SMAX, 1'b0);
    send_sample(SMIN, 1'b1);
    // Short frame with small negative values.
    send_sample(SAMPLE_BITS'(-1), 1'b0);
    send_sample(SAMPLE_BITS'(-2), 1'b0);
    send_sample('0, 1'b1);
    // Long frame: the window saturates, then the full tail flushes.
    for (int i = 0; i < 2 * RADIUS + 2; i++) begin
      send_sample((i < 8) ? SMAX : SMIN, i == 2 * RADIUS + 1);
    end
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == 2 && sent == 0) begin
          // Long receiver hold-off while a long frame keeps coming.
          hold_asked++;
          len = 40;
        end else if ($urandom_range(3) == 0) begin
          len = $urandom_range(1, RADIUS + 1);
        end else begin
          len = $urandom_range(RADIUS + 2, 40);
        end
        send_frame(len);
        sent += len;
        // Pause the sender once in the middle of phase 1 until everything has come out.
        if (phase == 1 && sent >= ITEMS_PER_PHASE / 2 && sent - len < ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("centered_box_filter_edge_truncated_unit: match");
    end else begin
      $display("centered_box_filter_edge_truncated_unit: mismatch");
    end
    $finish;
  end

endmodule
